### rtl/kth_pkg.sv
// kth_pkg: types, code point constants and the half-width kana table
// for the katakana to hiragana folder. no dependencies.

package kth_pkg;

  localparam int CpW   = 21;
  localparam int KanaW = 16;
  localparam int CntW  = 2;

  localparam logic [CpW-1:0] FullKataLo = 21'h030A1;
  localparam logic [CpW-1:0] FullKataHi = 21'h030F6;
  localparam logic [CpW-1:0] KataOffset = 21'h00060;
  localparam logic [CpW-1:0] HalfKataLo = 21'h0FF66;
  localparam logic [CpW-1:0] HalfKataHi = 21'h0FF9D;
  localparam logic [CpW-1:0] Dakuten    = 21'h0FF9E;
  localparam logic [CpW-1:0] Handakuten = 21'h0FF9F;

  localparam logic [KanaW-1:0] KanaU     = 16'h3046;
  localparam logic [KanaW-1:0] KanaVu    = 16'h3094;
  localparam logic [KanaW-1:0] DakLo0    = 16'h304B;
  localparam logic [KanaW-1:0] DakHi0    = 16'h3062;
  localparam logic [KanaW-1:0] DakLo1    = 16'h3064;
  localparam logic [KanaW-1:0] DakHi1    = 16'h3068;
  localparam logic [KanaW-1:0] HandLo    = 16'h306F;
  localparam logic [KanaW-1:0] HandHi    = 16'h307B;

  localparam logic [5:0] HalfIdxBase = 6'h26;

  localparam logic [CntW-1:0] QueueDepth = 2'd2;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           is_last;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] out_point;
    logic           run_last;
    logic           string_last;
  } out_item_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    out_item_t       first;
    out_item_t       second;
  } fold_res_t;

  function automatic logic [KanaW-1:0] half_map(input logic [5:0] idx);
    logic [KanaW-1:0] v;
    v = '0;
    unique case (idx)
      6'd0:  v = 16'h3092;
      6'd1:  v = 16'h3041;
      6'd2:  v = 16'h3043;
      6'd3:  v = 16'h3045;
      6'd4:  v = 16'h3047;
      6'd5:  v = 16'h3049;
      6'd6:  v = 16'h3083;
      6'd7:  v = 16'h3085;
      6'd8:  v = 16'h3087;
      6'd9:  v = 16'h3063;
      6'd10: v = 16'h30FC;
      6'd11: v = 16'h3042;
      6'd12: v = 16'h3044;
      6'd13: v = 16'h3046;
      6'd14: v = 16'h3048;
      6'd15: v = 16'h304A;
      6'd16: v = 16'h304B;
      6'd17: v = 16'h304D;
      6'd18: v = 16'h304F;
      6'd19: v = 16'h3051;
      6'd20: v = 16'h3053;
      6'd21: v = 16'h3055;
      6'd22: v = 16'h3057;
      6'd23: v = 16'h3059;
      6'd24: v = 16'h305B;
      6'd25: v = 16'h305D;
      6'd26: v = 16'h305F;
      6'd27: v = 16'h3061;
      6'd28: v = 16'h3064;
      6'd29: v = 16'h3066;
      6'd30: v = 16'h3068;
      6'd31: v = 16'h306A;
      6'd32: v = 16'h306B;
      6'd33: v = 16'h306C;
      6'd34: v = 16'h306D;
      6'd35: v = 16'h306E;
      6'd36: v = 16'h306F;
      6'd37: v = 16'h3072;
      6'd38: v = 16'h3075;
      6'd39: v = 16'h3078;
      6'd40: v = 16'h307B;
      6'd41: v = 16'h307E;
      6'd42: v = 16'h307F;
      6'd43: v = 16'h3080;
      6'd44: v = 16'h3081;
      6'd45: v = 16'h3082;
      6'd46: v = 16'h3084;
      6'd47: v = 16'h3086;
      6'd48: v = 16'h3088;
      6'd49: v = 16'h3089;
      6'd50: v = 16'h308A;
      6'd51: v = 16'h308B;
      6'd52: v = 16'h308C;
      6'd53: v = 16'h308D;
      6'd54: v = 16'h308F;
      6'd55: v = 16'h3093;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/kth_fold.sv
// kth_fold: conversion logic for one registered item plus the held kana register.
// depends on kth_pkg.

module kth_fold (
  input  logic              clk,
  input  logic              rst_n,
  input  kth_pkg::in_item_t item,
  input  logic              advance,
  output kth_pkg::fold_res_t res
);
  import kth_pkg::*;

  logic             held_valid_r, held_valid_nxt;
  logic [KanaW-1:0] held_kana_r, held_kana_nxt;

  logic [CpW-1:0]   cp;
  logic             is_full, is_half, is_dak, is_hand;
  logic             can_dak, can_hand;
  logic             fold_hit, flush, main_emit, store;
  logic [KanaW-1:0] half_val;
  logic [KanaW-1:0] fold_val;
  logic [CpW-1:0]   main_val;
  logic [CpW-1:0]   held_cp;

  assign cp      = item.code_point;
  assign is_full = (cp >= FullKataLo) && (cp <= FullKataHi);
  assign is_half = (cp >= HalfKataLo) && (cp <= HalfKataHi);
  assign is_dak  = (cp == Dakuten);
  assign is_hand = (cp == Handakuten);

  assign can_hand = (held_kana_r >= HandLo) && (held_kana_r <= HandHi);
  assign can_dak  = ((held_kana_r >= DakLo0) && (held_kana_r <= DakHi0)) ||
                    ((held_kana_r >= DakLo1) && (held_kana_r <= DakHi1)) ||
                    can_hand || (held_kana_r == KanaU);

  assign fold_hit = held_valid_r && ((is_dak && can_dak) || (is_hand && can_hand));
  assign flush    = held_valid_r && !fold_hit;

  always_comb begin
    if (is_dak) begin
      fold_val = (held_kana_r == KanaU) ? KanaVu : held_kana_r + 16'd1;
    end else begin
      fold_val = held_kana_r + 16'd2;
    end
  end

  assign half_val = half_map(cp[5:0] - HalfIdxBase);
  assign held_cp  = {{(CpW-KanaW){1'b0}}, held_kana_r};

  always_comb begin
    if (is_full) begin
      main_val = cp - KataOffset;
    end else if (is_half) begin
      main_val = {{(CpW-KanaW){1'b0}}, half_val};
    end else begin
      main_val = cp;
    end
  end

  assign store     = !fold_hit && is_half && !item.is_last;
  assign main_emit = !fold_hit && !store;

  always_comb begin
    res = '0;
    if (fold_hit) begin
      res.cnt               = 2'd1;
      res.first.out_point   = {{(CpW-KanaW){1'b0}}, fold_val};
      res.first.run_last    = 1'b1;
      res.first.string_last = item.is_last;
    end else if (flush && main_emit) begin
      res.cnt                = 2'd2;
      res.first.out_point    = held_cp;
      res.second.out_point   = main_val;
      res.second.run_last    = 1'b1;
      res.second.string_last = item.is_last;
    end else if (flush || main_emit) begin
      res.cnt               = 2'd1;
      res.first.out_point   = flush ? held_cp : main_val;
      res.first.run_last    = 1'b1;
      res.first.string_last = item.is_last;
    end
  end

  always_comb begin
    held_valid_nxt = held_valid_r;
    held_kana_nxt  = held_kana_r;
    if (advance) begin
      held_valid_nxt = store;
      held_kana_nxt  = store ? half_val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      held_kana_r  <= '0;
    end else begin
      held_valid_r <= held_valid_nxt;
      held_kana_r  <= held_kana_nxt;
    end
  end

endmodule

### rtl/kth_outq.sv
// kth_outq: two-entry result queue, takes up to two items per cycle, gives one while out_ready is high.
// depends on kth_pkg.

module kth_outq (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [kth_pkg::CntW-1:0] push_cnt,
  input  kth_pkg::out_item_t     push0,
  input  kth_pkg::out_item_t     push1,
  output logic [kth_pkg::CntW-1:0] free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output kth_pkg::out_item_t     out_item
);
  import kth_pkg::*;

  out_item_t       ent0_r, ent0_nxt;
  out_item_t       ent1_r, ent1_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] cnt_after;
  logic            pop;

  assign out_valid = (cnt_r != '0);
  assign out_item  = ent0_r;
  assign pop       = out_valid && out_ready;
  assign cnt_after = cnt_r - {{(CntW-1){1'b0}}, pop};
  assign free      = QueueDepth - cnt_after;

  always_comb begin
    ent0_nxt = ent0_r;
    ent1_nxt = ent1_r;
    unique case (cnt_after)
      2'd0: begin
        ent0_nxt = push0;
        ent1_nxt = push1;
      end
      2'd1: begin
        ent0_nxt = pop ? ent1_r : ent0_r;
        ent1_nxt = push0;
      end
      default: begin
        ent0_nxt = ent0_r;
        ent1_nxt = ent1_r;
      end
    endcase
    cnt_nxt = cnt_after + push_cnt;
  end

  always_ff @(posedge clk) begin
    ent0_r <= ent0_nxt;
    ent1_r <= ent1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/katakana_to_hiragana_folder_core.sv
// katakana_to_hiragana_folder_core: top level, input register, fold logic and result queue.
// depends on kth_pkg, kth_fold, kth_outq.

// Takes one decoded code point per item and returns zero, one or two converted
// code points. An item can be accepted on every clock while the input register is
// empty or its item is being consumed; an accepted item waits in the input register
// until the two-entry result queue has room for its results, then they are written
// into the queue, which drives out_valid.
// The output channel gives one result per cycle while out_ready is high, so an item
// that flushes a held half-width kana and also emits its own result gives two
// results; the sustained rate is one item per cycle as long as each item yields at
// most one result and out_ready stays high. A half-width kana not at end of string
// yields nothing until the next item, which may fold a dakuten or handakuten into it.

module katakana_to_hiragana_folder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kth_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output kth_pkg::out_item_t out_item
);
  import kth_pkg::*;

  logic            item_valid_r, item_valid_nxt;
  in_item_t        item_r;
  fold_res_t       res;
  logic [CntW-1:0] free;
  logic [CntW-1:0] push_cnt;
  logic            consume;
  logic            in_fire;

  assign consume  = item_valid_r && (res.cnt <= free);
  assign in_ready = !item_valid_r || consume;
  assign in_fire  = in_valid && in_ready;
  assign push_cnt = consume ? res.cnt : '0;

  always_comb begin
    item_valid_nxt = in_fire || (item_valid_r && !consume);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  kth_fold u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item_r),
    .advance (consume),
    .res     (res)
  );

  kth_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (res.first),
    .push1     (res.second),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### rtl/kth_checker.sv
// kth_checker: port-level checks for katakana_to_hiragana_folder_core, with its bind.
// depends on kth_pkg.

module kth_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input kth_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input kth_pkg::out_item_t out_item
);
  import kth_pkg::*;

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // full-width katakana never leaves the block
  a_no_full_kata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_item.out_point >= FullKataLo) &&
                    (out_item.out_point <= FullKataHi)))
    else $error("full-width katakana in result");

  // half-width kana is always mapped
  a_no_half_kata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((out_item.out_point >= HalfKataLo) &&
                    (out_item.out_point <= HalfKataHi)))
    else $error("half-width katakana in result");

  // end of string is always the last result of its item
  a_string_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.string_last |-> out_item.run_last)
    else $error("string end not on last result of item");

endmodule

bind katakana_to_hiragana_folder_core kth_checker u_kth_checker (.*);
